// File: sv/ncl_pkg.sv
// Shared types and constants of the nearest cell lookup.
package ncl_pkg;

	// Width of one cell index field.
	localparam int CELL_BITS = 8;

	// Item kind codes.
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// Control that travels alongside an entry through the distance pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

// File: sv/ncl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ncl_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [AW-1:0]            rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// File: sv/ncl_dist.sv
// Squared-distance unit: absolute differences, then squares, one entry per cycle.
module ncl_dist #(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ncl_pkg::tag_t             tag_in,
	input  logic [COORD_BITS-1:0]     cx,
	input  logic [COORD_BITS-1:0]     cy,
	input  logic [COORD_BITS-1:0]     px,
	input  logic [COORD_BITS-1:0]     py,
	input  logic [2*ncl_pkg::CELL_BITS-1:0] cell_in,
	output ncl_pkg::tag_t             tag_out,
	output logic [2*COORD_BITS:0]     dist_sq,
	output logic [2*ncl_pkg::CELL_BITS-1:0] cell_out
);
	ncl_pkg::tag_t                     tag_s2, tag_s3;
	logic [COORD_BITS-1:0]             dx_s2, dy_s2;
	logic [2*COORD_BITS-1:0]           sqx_s3, sqy_s3;
	logic [2*ncl_pkg::CELL_BITS-1:0]   cell_s2, cell_s3;

	// Pipeline control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
		end
	end

	// Absolute differences, then their squares.
	always_ff @(posedge clk) begin
		dx_s2   <= (cx >= px) ? (cx - px) : (px - cx);
		dy_s2   <= (cy >= py) ? (cy - py) : (py - cy);
		cell_s2 <= cell_in;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		cell_s3 <= cell_s2;
	end

	// The sum of squares feeds the compare in the sequencer.
	assign dist_sq  = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign tag_out  = tag_s3;
	assign cell_out = cell_s3;
endmodule

// File: sv/nearest_cell_lookup.sv
// Nearest cell lookup: table of centers with cells, searched by squared Euclidean distance.
// Clear, append and unused kinds give their result one cycle after start is taken.
// A query scans the stored entries in order (an empty table answers in the cycle after start);
// the distance unit handles one entry per cycle, so the table read sets the pace.
// The result strobe done is high for exactly one cycle; busy is high during a query.
// Reset empties the table at once; the table memory itself is not cleared.
module nearest_cell_lookup #(
	parameter int MAX_CELLS  = 256,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [7:0]            entry_cell_x,
	input  logic [7:0]            entry_cell_y,
	output logic                  done,
	output logic [7:0]            cell_x,
	output logic [7:0]            cell_y,
	output logic                  found,
	output logic                  table_full
);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int CB = ncl_pkg::CELL_BITS;
	localparam int RW = 2 * COORD_BITS + 2 * CB;
	localparam int DW = 2 * COORD_BITS + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           scan_idx_q;
	logic [COORD_BITS-1:0]   pos_x_q, pos_y_q;
	logic                    have_q;
	logic [DW-1:0]           best_q;
	logic [2*CB-1:0]         best_cell_q;
	logic                    done_q, found_q, full_q;
	logic [CB-1:0]           cell_x_q, cell_y_q;
	ncl_pkg::tag_t           tag_s1, tag_d;
	logic [DW-1:0]           dist_d;
	logic [2*CB-1:0]         cell_d;
	logic [RW-1:0]           rd_data;
	logic                    accept;
	logic                    wr_en;
	logic                    take;
	logic [2*CB-1:0]         sel_cell;
	logic                    done_set;

	assign accept = start && (state_q == ST_IDLE);
	assign wr_en  = accept && (kind == ncl_pkg::KIND_APPEND) && (count_q < CW'(MAX_CELLS));

	// A result is due at once unless a query has entries to scan, else when the last entry leaves the distance unit.
	assign done_set = (accept && ((kind != ncl_pkg::KIND_QUERY) || (count_q == '0))) ||
		((state_q == ST_DRAIN) && tag_d.valid && tag_d.last);

	// Table memory: cell y, cell x, center y, center x from high to low.
	ncl_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_CELLS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data({entry_cell_y, entry_cell_x, pos_y, pos_x}),
		.rd_addr(scan_idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// Distance unit fed by the registered table read.
	ncl_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s1),
		.cx      (rd_data[COORD_BITS-1:0]),
		.cy      (rd_data[2*COORD_BITS-1:COORD_BITS]),
		.px      (pos_x_q),
		.py      (pos_y_q),
		.cell_in (rd_data[RW-1:2*COORD_BITS]),
		.tag_out (tag_d),
		.dist_sq (dist_d),
		.cell_out(cell_d)
	);

	// Strictly smaller distance wins, so the earliest entry keeps a tie.
	assign take     = tag_d.valid && (!have_q || (dist_d < best_q));
	assign sel_cell = take ? cell_d : best_cell_q;

	// Sequencer, table count and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			tag_s1     <= '0;
			have_q     <= 1'b0;
			done_q     <= 1'b0;
			found_q    <= 1'b0;
			full_q     <= 1'b0;
			cell_x_q   <= '0;
			cell_y_q   <= '0;
		end else begin
			done_q       <= done_set;
			tag_s1.valid <= (state_q == ST_SCAN);
			tag_s1.last  <= (state_q == ST_SCAN) && (scan_idx_q == count_q - CW'(1));
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_x_q    <= pos_x;
						pos_y_q    <= pos_y;
						scan_idx_q <= '0;
						have_q     <= 1'b0;
						cell_x_q   <= '0;
						cell_y_q   <= '0;
						found_q    <= 1'b0;
						full_q     <= 1'b0;
						case (kind)
							ncl_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							ncl_pkg::KIND_APPEND: begin
								if (count_q < CW'(MAX_CELLS)) begin
									count_q <= count_q + CW'(1);
								end else begin
									full_q <= 1'b1;
								end
							end
							ncl_pkg::KIND_QUERY: begin
								if (count_q != '0) begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == count_q - CW'(1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (tag_d.valid && tag_d.last) begin
						state_q  <= ST_IDLE;
						found_q  <= 1'b1;
						cell_x_q <= sel_cell[CB-1:0];
						cell_y_q <= sel_cell[2*CB-1:CB];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Running best over the entries leaving the distance unit.
			if (take) begin
				have_q      <= 1'b1;
				best_q      <= dist_d;
				best_cell_q <= cell_d;
			end
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign cell_x     = cell_x_q;
	assign cell_y     = cell_y_q;
	assign found      = found_q;
	assign table_full = full_q;

	// The table never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CELLS))
		else $error("entry count beyond table depth");

	// A result never reports a match and a dropped append together.
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(found_q && full_q))
		else $error("found and table_full both set");

	// Table reads are issued only while a query runs.
	a_read_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("table read outside a query");

	// A query ends only by delivering its result.
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done_q && found_q))
		else $error("query finished without a result");
endmodule
